// ===== hw/rtl/bpca_pkg.sv =====
// Package with shared types and constants of the bit pair correlation accumulator.
package bpca_pkg;

    typedef enum logic [1:0] {
        OP_ACCUMULATE = 2'd0,
        OP_READ       = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_ACCUM,
        S_READ_WAIT,
        S_READ_DATA,
        S_RESULT
    } state_t;

    localparam int unsigned OP_WIDTH     = 2;
    localparam int unsigned SAMPLE_WIDTH = 64;
    localparam int unsigned INDEX_WIDTH  = 6;
    localparam int unsigned SUM_OUT_W    = 48;
    localparam int unsigned COUNT_OUT_W  = 47;
    localparam int unsigned CFG_WIDTH    = 7;
    localparam int unsigned STATUS_WIDTH = 2;

endpackage

// ===== hw/rtl/bpca_if.sv =====
// Valid/ready channel interfaces for input and result words.
interface bpca_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [bpca_pkg::OP_WIDTH-1:0]         operation;
    logic [bpca_pkg::SAMPLE_WIDTH-1:0]     sample_bits;
    logic [bpca_pkg::INDEX_WIDTH-1:0]      first_index;
    logic [bpca_pkg::INDEX_WIDTH-1:0]      second_index;

    modport source (output valid, operation, sample_bits, first_index, second_index,
                    input ready);
    modport sink (input valid, operation, sample_bits, first_index, second_index,
                  output ready);
endinterface

interface bpca_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [bpca_pkg::SUM_OUT_W-1:0]    sum_value;
    logic [bpca_pkg::COUNT_OUT_W-1:0]         samples_seen;
    logic [bpca_pkg::STATUS_WIDTH-1:0]        status;

    modport source (output valid, sum_value, samples_seen, status, input ready);
    modport sink (input valid, sum_value, samples_seen, status, output ready);
endinterface

// ===== hw/rtl/bpca_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bpca_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/bpca_lane.sv =====
// One lane: a column of row-indexed sums, updated with +1 or -1 per row step.
module bpca_lane #(
    parameter int unsigned ROWS      = 64,
    parameter int unsigned SUM_WIDTH = 48
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic                        clear_en,
    input  logic [$clog2(ROWS)-1:0]     waddr,
    input  logic                        minus,
    input  logic [SUM_WIDTH-1:0]        old_sum,
    input  logic [$clog2(ROWS)-1:0]     raddr,
    output logic [SUM_WIDTH-1:0]        rdata
);
    logic [SUM_WIDTH-1:0] wdata;

    // Sums cannot overflow since the sample count is limited.
    assign wdata = clear_en ? '0 :
                   (minus ? old_sum - SUM_WIDTH'(1) : old_sum + SUM_WIDTH'(1));

    bpca_ram #(.WIDTH(SUM_WIDTH), .DEPTH(ROWS)) u_ram (
        .clk   (clk),
        .we    (wr_en || clear_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );
endmodule

// ===== hw/rtl/bit_pair_correlation_accumulator.sv =====
// Top level of the bit pair correlation accumulator.
// The block keeps one signed sum for every used bit of a sample and one for
// every pair of used bits, in MAX_BITS lanes that each hold one column of sums
// in a small RAM. Lane 0 holds the single-bit sums, row j; lane d (d >= 1)
// holds the pair sum of bits j and j+d in row j. An accumulate word walks the
// rows j = 0 .. bits_in_use-1, one row per cycle, each row read in the cycle
// before it is written, so all lanes update in parallel; a clear writes one
// row of every lane per cycle. The merging stage picks one lane's value for a
// read. Results sit in an output register that is separate from the working
// registers, so a new word is taken while the previous result still waits;
// that new word then holds in its last cycle until the output register is
// free. After reset every store reads as zero once a clearing pass over all
// MAX_BITS rows has run; no word is accepted during it and it posts no result,
// while writes of bits_in_use are taken at any time.
module bit_pair_correlation_accumulator #(
    parameter int unsigned MAX_BITS  = 64,
    parameter int unsigned SUM_WIDTH = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bpca_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    bpca_in_if.sink                          in_ch,
    bpca_out_if.source                       out_ch
);
    import bpca_pkg::*;

    localparam int unsigned RW = $clog2(MAX_BITS);
    localparam logic [SUM_WIDTH-2:0] COUNT_LIMIT = '1;

    state_t                   state_reg, state_next;
    logic [CFG_WIDTH-1:0]     bits_reg;
    logic [6:0]               len;
    logic [RW:0]              row_reg, row_next;
    logic [SAMPLE_WIDTH-1:0]  sample_reg;
    logic [SUM_WIDTH-2:0]     count_reg;
    logic [RW-1:0]            rd_lane_reg;
    logic [RW-1:0]            rd_row_reg;
    logic                     wr_valid_reg;
    logic [RW-1:0]            wr_row_reg;
    logic                     init_reg;
    logic signed [SUM_OUT_W-1:0]   sum_reg;
    logic [STATUS_WIDTH-1:0]  status_reg;
    logic signed [SUM_OUT_W-1:0]   out_sum_reg;
    logic [STATUS_WIDTH-1:0]  out_status_reg;
    logic [COUNT_OUT_W-1:0]   seen_reg;
    logic                     accept;
    logic [SUM_WIDTH-1:0]     lane_data [MAX_BITS];
    logic [RW-1:0]            lane_raddr;
    logic                     clearing;
    logic [SUM_WIDTH-1:0]     picked;

    // Effective number of bits, saturated into 2..MAX_BITS.
    always_comb
    begin
        if (bits_reg < 7'd2)
            len = 7'd2;
        else if ({25'd0, bits_reg} > MAX_BITS)
            len = 7'(MAX_BITS);
        else
            len = bits_reg;
    end

    assign accept     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign clearing   = (state_reg == S_CLEAR);

    assign lane_raddr = (state_reg == S_ACCUM) ? row_reg[RW-1:0] : rd_row_reg;

    genvar d;
    generate
        for (d = 0; d < MAX_BITS; d++)
        begin : g_lane
            logic minus;
            logic wr_en;
            // Row j of lane d pairs bit j with bit j+d; lane 0 is the single sum.
            if (d == 0)
            begin : g_single
                assign minus = sample_reg[wr_row_reg];
                assign wr_en = wr_valid_reg;
            end
            else
            begin : g_pair
                logic [RW:0] partner;
                assign partner = {1'b0, wr_row_reg} + (RW+1)'(d);
                assign minus = sample_reg[wr_row_reg] ^ sample_reg[partner[RW-1:0]];
                assign wr_en = wr_valid_reg && ({1'b0, partner} < {1'b0, len[RW:0]}) &&
                               !partner[RW];
            end
            bpca_lane #(.ROWS(MAX_BITS), .SUM_WIDTH(SUM_WIDTH)) u_lane (
                .clk      (clk),
                .wr_en    (wr_en),
                .clear_en (clearing),
                .waddr    (clearing ? row_reg[RW-1:0] : wr_row_reg),
                .minus    (minus),
                .old_sum  (lane_data[d]),
                .raddr    (lane_raddr),
                .rdata    (lane_data[d])
            );
        end
    endgenerate

    // Merging stage: the read picks one lane.
    assign picked = lane_data[rd_lane_reg];

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                row_next = '0;
                if (accept)
                begin
                    unique case (op_t'(in_ch.operation))
                        OP_ACCUMULATE:
                            state_next = (count_reg == COUNT_LIMIT) ? S_RESULT : S_ACCUM;
                        OP_READ:
                            state_next = (({1'b0, in_ch.first_index} >= len) ||
                                          ({1'b0, in_ch.second_index} >= len)) ?
                                         S_RESULT : S_READ_WAIT;
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_NONE:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                row_next = row_reg + 1'b1;
                // The pass after reset answers nothing.
                if (row_reg[RW-1:0] == RW'(MAX_BITS - 1))
                    state_next = init_reg ? S_IDLE : S_RESULT;
            end
            S_ACCUM:
            begin
                row_next = row_reg + 1'b1;
                if (row_reg == (RW+1)'(len - 7'd1))
                    state_next = S_RESULT;
            end
            S_READ_WAIT: state_next = S_READ_DATA;
            S_READ_DATA: state_next = S_RESULT;
            S_RESULT:
            begin
                if (!out_ch.valid || out_ch.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            row_reg      <= '0;
            bits_reg     <= 7'd64;
            count_reg    <= '0;
            wr_valid_reg <= 1'b0;
            init_reg     <= 1'b1;
            out_ch.valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            if (cfg_we)
                bits_reg <= cfg_wdata;
            wr_valid_reg <= (state_reg == S_ACCUM);
            if (state_reg == S_CLEAR && state_next != S_CLEAR)
                init_reg <= 1'b0;
            // Result is posted on leaving S_RESULT, after the previous one left.
            if (state_reg == S_RESULT && state_next == S_IDLE)
                out_ch.valid <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                out_ch.valid <= 1'b0;
            if (accept && op_t'(in_ch.operation) == OP_CLEAR)
                count_reg <= '0;
            else if (state_reg == S_ACCUM && state_next == S_RESULT)
                count_reg <= count_reg + 1'b1;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        wr_row_reg <= row_reg[RW-1:0];
        if (accept)
        begin
            sample_reg <= in_ch.sample_bits;
            if (in_ch.first_index <= in_ch.second_index)
            begin
                rd_row_reg  <= RW'(in_ch.first_index);
                rd_lane_reg <= RW'(in_ch.second_index - in_ch.first_index);
            end
            else
            begin
                rd_row_reg  <= RW'(in_ch.second_index);
                rd_lane_reg <= RW'(in_ch.first_index - in_ch.second_index);
            end
            sum_reg <= '0;
            if (op_t'(in_ch.operation) == OP_ACCUMULATE && count_reg == COUNT_LIMIT)
                status_reg <= ST_FULL;
            else if (op_t'(in_ch.operation) == OP_READ &&
                     (({1'b0, in_ch.first_index} >= len) ||
                      ({1'b0, in_ch.second_index} >= len)))
                status_reg <= ST_BAD_INDEX;
            else
                status_reg <= ST_OK;
        end
        else if (state_reg == S_READ_DATA)
            sum_reg <= SUM_OUT_W'($signed(picked));
        if (state_reg == S_RESULT && state_next == S_IDLE)
        begin
            seen_reg       <= COUNT_OUT_W'(count_reg);
            out_sum_reg    <= sum_reg;
            out_status_reg <= status_reg;
        end
    end

    assign out_ch.sum_value    = out_sum_reg;
    assign out_ch.samples_seen = seen_reg;
    assign out_ch.status       = out_status_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid || out_ch.ready || state_reg == S_IDLE)
        else $error("ready outside idle");
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        $past(count_reg) == COUNT_LIMIT |-> count_reg == COUNT_LIMIT || count_reg == '0)
        else $error("count moved past limit");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACCUM |-> !in_ch.ready)
        else $error("accepted during accumulate");
    a_wr_follows: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> $past(state_reg) == S_ACCUM)
        else $error("row write without accumulate");
`endif
endmodule

// ===== test/bit_pair_correlation_accumulator_tb.sv =====
// Testbench for the bit pair correlation accumulator: directed and random words against a predictor.
module bit_pair_correlation_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpca_pkg::*;

    localparam int NBITS = 64;
    localparam int NPAIRS = NBITS * (NBITS - 1) / 2;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic signed [SUM_OUT_W-1:0] sum;
        logic [COUNT_OUT_W-1:0]      count;
        status_t                     status;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;

    bpca_in_if  in_ch();
    bpca_out_if out_ch();

    bit_pair_correlation_accumulator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #4 clk = ~clk;

    // Predictor state: its own copy of every store and of the register.
    longint bit_sums [NBITS];
    longint pair_sums_m [NPAIRS];
    longint sample_total;
    int unsigned width_reg;
    answer_t pending_answers[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint cycles = 0;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.operation = OP_NONE;
        in_ch.sample_bits = '0;
        in_ch.first_index = '0;
        in_ch.second_index = '0;
        out_ch.ready = 1'b0;
    end

    function automatic int pair_index(int j, int k);
        return (j * (2 * NBITS - j - 1)) / 2 + (k - j - 1);
    endfunction

    function automatic int used_width();
        int w;
        w = width_reg;
        if (w < 2) w = 2;
        if (w > NBITS) w = NBITS;
        return w;
    endfunction

    // Works out the answer the block owes for one word, updating the stores.
    function automatic void predict_word(op_t op, logic [63:0] smp, int a, int b);
        answer_t r;
        int len;
        int lo;
        int hi;
        len = used_width();
        r.sum = '0;
        r.status = ST_OK;
        case (op)
            OP_ACCUMULATE:
            begin
                if (sample_total >= (64'd1 << (SUM_OUT_W - 1)) - 1)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (int j = 0; j < len; j++)
                    begin
                        bit_sums[j] += smp[j] ? -1 : 1;
                        for (int k = j + 1; k < len; k++)
                            pair_sums_m[pair_index(j, k)] += (smp[j] ^ smp[k]) ? -1 : 1;
                    end
                    sample_total++;
                end
            end
            OP_READ:
            begin
                if (a >= len || b >= len)
                    r.status = ST_BAD_INDEX;
                else if (a == b)
                    r.sum = SUM_OUT_W'(bit_sums[a]);
                else
                begin
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                    r.sum = SUM_OUT_W'(pair_sums_m[pair_index(lo, hi)]);
                end
            end
            OP_CLEAR:
            begin
                foreach (bit_sums[i]) bit_sums[i] = 0;
                foreach (pair_sums_m[i]) pair_sums_m[i] = 0;
                sample_total = 0;
            end
            default: return;
        endcase
        r.count = COUNT_OUT_W'(sample_total);
        pending_answers.push_back(r);
    endfunction

    // Sends one word, with random idle cycles before it, and predicts its answer.
    task automatic send_word(op_t op, logic [63:0] smp, int a, int b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.sample_bits <= smp;
        in_ch.first_index <= INDEX_WIDTH'(a);
        in_ch.second_index <= INDEX_WIDTH'(b);
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_word(op, smp, a, b);
        @(negedge clk);
    endtask

    // Receiver: random stalls, and each result word checked against the oldest answer.
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        answer_t e;
        cycles++;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: sum %0d count %0d status %0d",
                             out_ch.sum_value, out_ch.samples_seen, out_ch.status);
            end
            else
            begin
                e = pending_answers.pop_front();
                if (out_ch.sum_value !== e.sum || out_ch.samples_seen !== e.count
                    || out_ch.status !== e.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: sum %0d/%0d count %0d/%0d status %0d/%0d",
                                 e.sum, out_ch.sum_value, e.count, out_ch.samples_seen,
                                 e.status, out_ch.status);
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Waits until every answer is back, plus the longest block latency.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (NBITS + 8) @(negedge clk);
    endtask

    task automatic write_width(int unsigned w);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= CFG_WIDTH'(w);
        @(negedge clk);
        cfg_we <= 1'b0;
        width_reg = w & 7'h7f;
    endtask

    function automatic logic [63:0] rand_sample();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Extremes of every field, all operations, bad indexes, swapped indexes
    // and the unused operation code.
    task automatic test_directed();
        send_word(OP_READ, '0, 0, 0);
        send_word(OP_ACCUMULATE, '0, 0, 0);
        send_word(OP_ACCUMULATE, '1, 63, 63);
        send_word(OP_ACCUMULATE, 64'h5555_5555_5555_5555, 0, 0);
        send_word(OP_ACCUMULATE, 64'h8000_0000_0000_0001, 0, 0);
        send_word(OP_READ, '0, 0, 0);
        send_word(OP_READ, '0, 63, 63);
        send_word(OP_READ, '0, 0, 63);
        send_word(OP_READ, '0, 63, 0);
        send_word(OP_READ, '0, 1, 2);
        send_word(OP_NONE, '1, 5, 6);
        send_word(OP_READ, '0, 2, 1);
        send_word(OP_CLEAR, '1, 63, 63);
        send_word(OP_READ, '0, 0, 1);
        write_width(2);
        send_word(OP_ACCUMULATE, 64'h2, 0, 0);
        send_word(OP_READ, '0, 0, 1);
        send_word(OP_READ, '0, 2, 0);
        send_word(OP_READ, '0, 1, 1);
        write_width(0);
        send_word(OP_ACCUMULATE, 64'h1, 0, 0);
        send_word(OP_READ, '0, 1, 0);
        write_width(127);
        send_word(OP_ACCUMULATE, 64'hffff_0000_ffff_0000, 0, 0);
        send_word(OP_READ, '0, 63, 62);
    endtask

    // Mostly accumulates and reads with random content, a few clears and dead codes.
    task automatic test_random(int n, int unsigned w);
        int p;
        write_width(w);
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(99);
            if (p < 45)
                send_word(OP_ACCUMULATE, rand_sample(), $urandom_range(63), $urandom_range(63));
            else if (p < 93)
                send_word(OP_READ, {$urandom, $urandom},
                          $urandom_range(w > 1 && w < 64 && p < 80 ? w - 1 : 63),
                          $urandom_range(63));
            else if (p < 96)
                send_word(OP_CLEAR, {$urandom, $urandom}, $urandom_range(63), $urandom_range(63));
            else
                send_word(OP_NONE, {$urandom, $urandom}, $urandom_range(63), $urandom_range(63));
        end
    endtask

    initial
    begin
        foreach (bit_sums[i]) bit_sums[i] = 0;
        foreach (pair_sums_m[i]) pair_sums_m[i] = 0;
        sample_total = 0;
        width_reg = 64;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(400, 64);
        send_idle_pct = 81;
        test_random(400, 7);
        send_idle_pct = 0;
        recv_stall_pct = 81;
        test_random(400, 33);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        test_random(400, 64);
        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
